// ===== hw/rtl/velocity_slew_gate_with_timeout_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the velocity slew gate
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_SLEW_GATE_WITH_TIMEOUT_ASSERT_SVH
`define VELOCITY_SLEW_GATE_WITH_TIMEOUT_ASSERT_SVH

// Same-cycle implication
`define VSG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define VSG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/vsg_pkg.sv =====
// ----------------------------------------------------------------------------
// vsg_pkg
// Types, codes and reset values shared by the velocity slew gate modules.
// ----------------------------------------------------------------------------
package vsg_pkg;

    // Default widths
    localparam int VEL_WIDTH_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int STEP_W  = 15;
    localparam int TOUT_W  = 16;
    localparam int KEYS_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [STEP_W-1:0] LINEAR_STEP_RST = 15'd82;
    localparam logic [STEP_W-1:0] YAW_STEP_RST    = 15'd205;
    localparam logic [TOUT_W-1:0] TIMEOUT_RST     = 16'd12;
    localparam logic [STEP_W-1:0] NEAR_ZERO_RST   = 15'd1;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CMD  = 2'd0,
        FUNC_KEYS = 2'd1,
        FUNC_TICK = 2'd2
    } t_func;

    // Result kinds
    localparam logic CMD_STOP = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINEAR_STEP = 2'd0,
        CFG_YAW_STEP    = 2'd1,
        CFG_TIMEOUT     = 2'd2,
        CFG_NEAR_ZERO   = 2'd3
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic [STEP_W-1:0] linear_step;
        logic [STEP_W-1:0] yaw_step;
        logic [TOUT_W-1:0] timeout_ticks;
        logic [STEP_W-1:0] near_zero_limit;
    } t_cfg;

endpackage

// ===== hw/rtl/vsg_cfg.sv =====
// ----------------------------------------------------------------------------
// vsg_cfg
// Configuration register file: step sizes, watchdog timeout, stop limit.
// ----------------------------------------------------------------------------
module vsg_cfg import vsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write one register per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_step     <= LINEAR_STEP_RST;
            r_cfg.yaw_step        <= YAW_STEP_RST;
            r_cfg.timeout_ticks   <= TIMEOUT_RST;
            r_cfg.near_zero_limit <= NEAR_ZERO_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LINEAR_STEP: r_cfg.linear_step     <= i_cfg_data[STEP_W-1:0];
                CFG_YAW_STEP:    r_cfg.yaw_step        <= i_cfg_data[STEP_W-1:0];
                CFG_TIMEOUT:     r_cfg.timeout_ticks   <= i_cfg_data[TOUT_W-1:0];
                CFG_NEAR_ZERO:   r_cfg.near_zero_limit <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/vsg_core.sv =====
// ----------------------------------------------------------------------------
// vsg_core
// Mode, goal, watchdog and slew state; computes the result of one item.
// ----------------------------------------------------------------------------
module vsg_core import vsg_pkg::*; #(
    parameter int VEL_WIDTH   = VEL_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_fire,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic signed [VEL_WIDTH-1:0] i_vel_x,
    input  logic signed [VEL_WIDTH-1:0] i_vel_y,
    input  logic signed [VEL_WIDTH-1:0] i_vel_yaw,
    input  logic [KEYS_W-1:0]           i_keys,
    output logic                        o_has_result,
    output logic                        o_command,
    output logic signed [VEL_WIDTH-1:0] o_vx,
    output logic signed [VEL_WIDTH-1:0] o_vy,
    output logic signed [VEL_WIDTH-1:0] o_vyaw
);

    // Wide enough for a velocity difference and a 15-bit magnitude
    localparam int SW = ((VEL_WIDTH > STEP_W) ? VEL_WIDTH : STEP_W) + 2;
    localparam int CW = (COUNT_WIDTH > TOUT_W) ? COUNT_WIDTH : TOUT_W;

    logic signed [VEL_WIDTH-1:0] r_goal_x, r_goal_y, r_goal_yaw;
    logic signed [VEL_WIDTH-1:0] r_smooth_x, r_smooth_y, r_smooth_yaw;
    logic                        r_auto_on;
    logic                        r_both_held;
    logic [COUNT_WIDTH-1:0]      r_ticks;

    logic                        both, rise, timed_out, all_near;
    logic [COUNT_WIDTH-1:0]      cnt_inc;
    logic signed [VEL_WIDTH-1:0] gx, gy, gw;
    logic signed [VEL_WIDTH-1:0] n_smooth_x, n_smooth_y, n_smooth_yaw;

    // Move cur toward goal by at most step
    function automatic logic signed [VEL_WIDTH-1:0] slew(
        input logic signed [VEL_WIDTH-1:0] cur,
        input logic signed [VEL_WIDTH-1:0] goal,
        input logic [STEP_W-1:0]           step
    );
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] s;
        d = SW'(goal) - SW'(cur);
        s = $signed(SW'(step));
        if (d > s) begin
            d = s;
        end else if (d < -s) begin
            d = -s;
        end
        return cur + d[VEL_WIDTH-1:0];
    endfunction

    // Magnitude strictly below the stop limit
    function automatic logic near_zero(
        input logic signed [VEL_WIDTH-1:0] v,
        input logic [STEP_W-1:0]           limit
    );
        logic signed [SW-1:0] m;
        m = SW'(v);
        if (m < 0) begin
            m = -m;
        end
        return m < $signed(SW'(limit));
    endfunction

    // Key edge and watchdog count
    assign both      = (i_keys[1:0] == 2'b11);
    assign rise      = both && !r_both_held;
    assign cnt_inc   = (r_ticks != '1) ? r_ticks + 1'b1 : r_ticks;
    assign timed_out = CW'(cnt_inc) > CW'(i_cfg.timeout_ticks);

    // Goals after the watchdog, then one slew step
    assign gx = timed_out ? '0 : r_goal_x;
    assign gy = timed_out ? '0 : r_goal_y;
    assign gw = timed_out ? '0 : r_goal_yaw;

    assign n_smooth_x   = slew(r_smooth_x, gx, i_cfg.linear_step);
    assign n_smooth_y   = slew(r_smooth_y, gy, i_cfg.linear_step);
    assign n_smooth_yaw = slew(r_smooth_yaw, gw, i_cfg.yaw_step);

    assign all_near = near_zero(n_smooth_x, i_cfg.near_zero_limit)
                   && near_zero(n_smooth_y, i_cfg.near_zero_limit)
                   && near_zero(n_smooth_yaw, i_cfg.near_zero_limit);

    // Result of the item at the head
    always_comb begin
        o_has_result = 1'b0;
        o_command    = CMD_STOP;
        o_vx         = '0;
        o_vy         = '0;
        o_vyaw       = '0;
        case (t_func'(i_func))
            FUNC_KEYS: begin
                o_has_result = rise && r_auto_on;
            end
            FUNC_TICK: begin
                o_has_result = r_auto_on;
                if (!all_near) begin
                    o_command = CMD_MOVE;
                    o_vx      = n_smooth_x;
                    o_vy      = n_smooth_y;
                    o_vyaw    = n_smooth_yaw;
                end
            end
            default: ;
        endcase
    end

    // Update state when the item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_goal_yaw   <= '0;
            r_smooth_x   <= '0;
            r_smooth_y   <= '0;
            r_smooth_yaw <= '0;
            r_auto_on    <= 1'b1;
            r_both_held  <= 1'b0;
            r_ticks      <= '0;
        end else if (i_fire) begin
            case (t_func'(i_func))
                FUNC_CMD: begin
                    if (r_auto_on) begin
                        r_goal_x   <= i_vel_x;
                        r_goal_y   <= i_vel_y;
                        r_goal_yaw <= i_vel_yaw;
                        r_ticks    <= '0;
                    end
                end
                FUNC_KEYS: begin
                    r_both_held <= both;
                    if (rise) begin
                        r_auto_on <= !r_auto_on;
                        if (r_auto_on) begin
                            r_goal_x     <= '0;
                            r_goal_y     <= '0;
                            r_goal_yaw   <= '0;
                            r_smooth_x   <= '0;
                            r_smooth_y   <= '0;
                            r_smooth_yaw <= '0;
                        end else begin
                            r_ticks <= '0;
                        end
                    end
                end
                FUNC_TICK: begin
                    if (r_auto_on) begin
                        r_ticks      <= cnt_inc;
                        r_smooth_x   <= n_smooth_x;
                        r_smooth_y   <= n_smooth_y;
                        r_smooth_yaw <= n_smooth_yaw;
                    end
                end
                default: ;
            endcase
        end
    end

    `include "velocity_slew_gate_with_timeout_assert.svh"

    `VSG_ASSERT_IMP(a_manual_still, !r_auto_on, (r_smooth_x == 0) && (r_smooth_y == 0) && (r_smooth_yaw == 0), "filtered values not zero in manual mode")
    `VSG_ASSERT_NXT(a_cmd_restart, i_fire && (i_func == FUNC_CMD) && r_auto_on, r_ticks == 0, "watchdog not restarted by command")
    `VSG_ASSERT_NXT(a_exit_auto, i_fire && (i_func == FUNC_KEYS) && o_has_result, !r_auto_on && (r_goal_x == 0), "leaving auto mode did not clear state")

endmodule

// ===== hw/rtl/velocity_slew_gate_with_timeout.sv =====
// ----------------------------------------------------------------------------
// velocity_slew_gate_with_timeout
// Three-axis velocity command gate with slew limit and command watchdog.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its output is not stalled:
// an item is registered on transfer, processed from the input register by a
// single slew/clamp pass, and its result (if any) is loaded into the output
// register. Items that give no result never wait.
// Input ready drops only while an item that gives a result meets a full
// output register that the downstream side is not taking. Configuration is
// written through its own port, always ready, and is meant for idle periods.
module velocity_slew_gate_with_timeout import vsg_pkg::*; #(
    parameter int VEL_WIDTH   = VEL_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: vel_x, vel_y, vel_yaw, keys, zero fill to bytes
    input  logic [((3*VEL_WIDTH+KEYS_W+7)/8)*8-1:0] s_axis_tdata,
    // tuser: func
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: out_vx, out_vy, out_vyaw, zero fill to bytes
    output logic [((3*VEL_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: command
    output logic                  m_axis_tuser
);

    localparam int OUT_TDATA_W = ((3*VEL_WIDTH+7)/8)*8;

    t_cfg                        cfg;
    logic                        r_in_valid;
    logic [FUNC_W-1:0]           r_func;
    logic signed [VEL_WIDTH-1:0] r_vel_x, r_vel_y, r_vel_yaw;
    logic [KEYS_W-1:0]           r_keys;
    logic                        r_out_valid;
    logic                        r_command;
    logic signed [VEL_WIDTH-1:0] r_vx, r_vy, r_vyaw;

    logic                        has_result, command, out_free, advance;
    logic signed [VEL_WIDTH-1:0] vx, vy, vyaw;

    vsg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vsg_core #(
        .VEL_WIDTH   (VEL_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_fire       (advance),
        .i_func       (r_func),
        .i_vel_x      (r_vel_x),
        .i_vel_y      (r_vel_y),
        .i_vel_yaw    (r_vel_yaw),
        .i_keys       (r_keys),
        .o_has_result (has_result),
        .o_command    (command),
        .o_vx         (vx),
        .o_vy         (vy),
        .o_vyaw       (vyaw)
    );

    // Advance the held item if it gives no result or its result has somewhere to go
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!has_result || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func    <= s_axis_tuser;
            r_vel_x   <= s_axis_tdata[VEL_WIDTH-1:0];
            r_vel_y   <= s_axis_tdata[2*VEL_WIDTH-1:VEL_WIDTH];
            r_vel_yaw <= s_axis_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH];
            r_keys    <= s_axis_tdata[3*VEL_WIDTH +: KEYS_W];
        end
    end

    // Output register: load a result, drop it on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_command <= command;
            r_vx      <= vx;
            r_vy      <= vy;
            r_vyaw    <= vyaw;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_command;
    assign m_axis_tdata  = OUT_TDATA_W'({r_vyaw, r_vy, r_vx});

endmodule
